// ===== design/cst_pkg.sv =====
// ---------------------------------------------------------------------------
// C source tokenizer package
// Shared types, constants and operator tables for the tokenizer core.
// ---------------------------------------------------------------------------
package cst_pkg;

   localparam int OffsetBits = 32;
   localparam int LengthBits = 16;
   localparam int DataBits   = 128;
   localparam int FifoDepth  = 4;
   localparam int PtrBits    = $clog2(FifoDepth);
   localparam int CountBits  = $clog2(FifoDepth + 1);

   // Lexer modes.
   typedef enum logic [3:0] {
      MODE_IDLE   = 4'd0,
      MODE_SLASH  = 4'd1,
      MODE_LINE   = 4'd2,
      MODE_BLOCK  = 4'd3,
      MODE_BSTAR  = 4'd4,
      MODE_OPER   = 4'd5,
      MODE_IDENT  = 4'd6,
      MODE_ZERO   = 4'd7,
      MODE_NUMBER = 4'd8,
      MODE_CHAR   = 4'd9,
      MODE_STRING = 4'd10
   } mode_type;

   typedef enum logic [1:0] {
      BASE_DEC = 2'd0,
      BASE_BIN = 2'd1,
      BASE_OCT = 2'd2,
      BASE_HEX = 2'd3
   } base_type;

   // Token kinds.
   localparam logic [2:0] KIND_END    = 3'd0;
   localparam logic [2:0] KIND_OTHER  = 3'd1;
   localparam logic [2:0] KIND_OPER   = 3'd2;
   localparam logic [2:0] KIND_IDENT  = 3'd3;
   localparam logic [2:0] KIND_INT    = 3'd4;
   localparam logic [2:0] KIND_FLOAT  = 3'd5;
   localparam logic [2:0] KIND_STRING = 3'd6;

   // Operator codes that are needed by name.
   localparam logic [5:0] OP_SLASH = 6'd3;
   localparam logic [5:0] OP_NONE  = 6'd36;
   localparam logic [3:0] OP_CHAR_NONE = 4'd12;

   typedef struct packed {
      mode_type                mode;
      base_type                base;
      logic                    float_seen;
      logic [5:0]              pend_op;
      logic [63:0]             acc;
      logic                    ovf;
      logic [LengthBits-1:0]   count;
      logic [7:0]              first_char;
      logic [OffsetBits-1:0]   start;
   } lex_state_type;

   localparam lex_state_type LEX_RESET = '{
      mode: MODE_IDLE, base: BASE_DEC, float_seen: 1'b0, pend_op: '0, acc: '0,
      ovf: 1'b0, count: '0, first_char: '0, start: '0};

   typedef struct packed {
      logic [2:0]              kind;
      logic [OffsetBits-1:0]   start;
      logic [LengthBits-1:0]   length;
      logic [5:0]              op_code;
      logic [7:0]              other_char;
      logic [63:0]             value;
      logic                    error;
      logic                    last;
   } result_type;

   // Index of a single-character operator, or none.
   function automatic logic [3:0] op_index(input logic [7:0] c);
      logic [3:0] idx;
      unique case (c)
         "+": idx = 4'd0;
         "-": idx = 4'd1;
         "*": idx = 4'd2;
         "/": idx = 4'd3;
         "%": idx = 4'd4;
         "&": idx = 4'd5;
         "|": idx = 4'd6;
         "^": idx = 4'd7;
         "!": idx = 4'd8;
         "=": idx = 4'd9;
         "<": idx = 4'd10;
         ">": idx = 4'd11;
         default: idx = OP_CHAR_NONE;
      endcase
      return idx;
   endfunction

   // Operator code after extending operator p by byte c, or none.
   function automatic logic [5:0] op_extend(input logic [5:0] p, input logic [7:0] c);
      logic [5:0] e;
      e = OP_NONE;
      if (p < 6'd12) begin
         if (c == "=") begin
            e = p + 6'd12;
         end else if ({2'b00, op_index(c)} == p) begin
            unique case (p)
               6'd0:  e = 6'd24;
               6'd1:  e = 6'd25;
               6'd5:  e = 6'd26;
               6'd6:  e = 6'd27;
               6'd7:  e = 6'd28;
               6'd10: e = 6'd29;
               6'd11: e = 6'd30;
               default: e = OP_NONE;
            endcase
         end
      end else if (p >= 6'd26 && p <= 6'd30 && c == "=") begin
         e = p + 6'd5;
      end
      return e;
   endfunction

endpackage

// ===== design/c_source_tokenizer_core.sv =====
// ---------------------------------------------------------------------------
// C source tokenizer core
// Splits a C source byte stream into tokens, one result item per token.
// ---------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one source byte per item in req_tdata; req_tlast
//   marks the end of the stream and its data byte is ignored. The rsp_ channel
//   returns one item per token: the token kind in rsp_tuser, the remaining
//   fields in rsp_tdata, and rsp_tlast on the final item caused by an input.
//   An input causes no, one or two result items; end of stream flushes any
//   pending token and then returns an end token, after which offsets restart
//   at zero.
//   Each accepted byte is lexed in the cycle it is accepted; its results are
//   written into a four-entry result queue and are offered on rsp_ from the
//   next cycle. One byte is accepted per clock while the queue has room for
//   two items; a byte that yields two tokens returns them one after the other
//   on the single output port, which sets the sustained rate.
//   When the receiver stalls, the queue fills and req_tready drops once fewer
//   than two entries are free; nothing is lost.
//   Synchronous reset empties the queue and returns the lexer to idle at
//   offset zero.
// ---------------------------------------------------------------------------
module c_source_tokenizer_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [7:0] in_byte
   input  logic                           req_tlast,   // end_of_input
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [cst_pkg::DataBits-1:0]   rsp_tdata,   // token_start, token_length,
                                                       // operator_code, other_char,
                                                       // integer_value, lex_error, pad
   output logic [2:0]                     rsp_tuser,   // token_kind
   output logic                           rsp_tlast    // last_of_run
);

   cst_pkg::lex_state_type               state_ff;
   cst_pkg::lex_state_type               state_in;
   logic [cst_pkg::OffsetBits-1:0]       pos_ff;
   logic [cst_pkg::OffsetBits-1:0]       pos_in;
   cst_pkg::result_type                  mem_ff [cst_pkg::FifoDepth];
   logic [cst_pkg::PtrBits-1:0]          wr_ptr_ff;
   logic [cst_pkg::PtrBits-1:0]          rd_ptr_ff;
   logic [cst_pkg::CountBits-1:0]        count_ff;
   logic [cst_pkg::CountBits-1:0]        count_in;
   logic [1:0]                           res_count;
   cst_pkg::result_type                  res_a;
   cst_pkg::result_type                  res_b;
   cst_pkg::result_type                  head;
   logic                                 accept;
   logic                                 pop;
   logic [1:0]                           push_count;

   cst_step u_step (
      .state        (state_ff),
      .pos          (pos_ff),
      .in_byte      (req_tdata),
      .end_of_input (req_tlast),
      .next_state   (state_in),
      .res_count    (res_count),
      .res_a        (res_a),
      .res_b        (res_b)
   );

   // Handshakes: take a byte while two queue entries are free.
   assign req_tready = count_ff <= cst_pkg::CountBits'(cst_pkg::FifoDepth - 2);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = count_ff != '0;
   assign pop        = rsp_tvalid && rsp_tready;
   assign push_count = accept ? res_count : 2'd0;
   assign pos_in     = req_tlast ? '0 : pos_ff + 1'b1;
   assign count_in   = count_ff + cst_pkg::CountBits'(push_count)
                       - cst_pkg::CountBits'(pop);

   // Lexer state and byte offset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cst_pkg::LEX_RESET;
         pos_ff   <= '0;
      end else if (accept) begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
      end
   end

   // Result queue control.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + cst_pkg::PtrBits'(push_count);
         rd_ptr_ff <= rd_ptr_ff + cst_pkg::PtrBits'(pop);
         count_ff  <= count_in;
      end
   end

   // Result queue storage.
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= res_a;
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_ptr_ff + cst_pkg::PtrBits'(1)] <= res_b;
      end
   end

   // Head of the queue drives the result port.
   assign head      = mem_ff[rd_ptr_ff];
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;
   assign rsp_tdata = {1'b0, head.error, head.value, head.other_char, head.op_code,
                       head.length, head.start};

   // The queue never holds more items than it has entries.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= cst_pkg::CountBits'(cst_pkg::FifoDepth))
      else $error("result queue overfilled");

   // End of stream always yields at least the end token.
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |-> (res_count != 2'd0))
      else $error("end of stream gave no result");

   // End of stream restarts offsets and the lexer.
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=> (pos_ff == '0 && state_ff.mode == cst_pkg::MODE_IDLE))
      else $error("end of stream did not restart the lexer");

   // A source byte advances the offset by one.
   assert property (@(posedge clock) disable iff (reset)
      (accept && !req_tlast) |=> (pos_ff == $past(pos_ff) + 1'b1))
      else $error("byte offset did not advance");

endmodule

// ===== design/cst_step.sv =====
// ---------------------------------------------------------------------------
// Tokenizer step
// Combinational next-state and result logic for one source byte.
// ---------------------------------------------------------------------------
module cst_step (
   input  cst_pkg::lex_state_type          state,
   input  logic [cst_pkg::OffsetBits-1:0]  pos,
   input  logic [7:0]                      in_byte,
   input  logic                            end_of_input,
   output cst_pkg::lex_state_type          next_state,
   output logic [1:0]                      res_count,
   output cst_pkg::result_type             res_a,
   output cst_pkg::result_type             res_b
);

   function automatic logic is_space(input logic [7:0] c);
      return (c == " ") || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c == "_");
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic [4:0] digit_value(input logic [7:0] c);
      logic [4:0] d;
      d = 5'd16;
      if (c >= "0" && c <= "9") d = 5'(c - "0");
      else if (c >= "a" && c <= "f") d = 5'(c - "a") + 5'd10;
      else if (c >= "A" && c <= "F") d = 5'(c - "A") + 5'd10;
      return d;
   endfunction

   function automatic logic [cst_pkg::LengthBits-1:0] count_up(
      input logic [cst_pkg::LengthBits-1:0] n);
      return (&n) ? n : n + 1'b1;
   endfunction

   // Whether a mode holds a token that is emitted on flush.
   function automatic logic has_token(input cst_pkg::mode_type m);
      return m == cst_pkg::MODE_SLASH || m == cst_pkg::MODE_OPER ||
             m == cst_pkg::MODE_IDENT || m == cst_pkg::MODE_ZERO ||
             m == cst_pkg::MODE_NUMBER || m == cst_pkg::MODE_CHAR ||
             m == cst_pkg::MODE_STRING;
   endfunction

   // Result item for the token pending in a state.
   function automatic cst_pkg::result_type flush_res(input cst_pkg::lex_state_type s);
      cst_pkg::result_type r;
      r = '0;
      r.start  = s.start;
      r.length = s.count;
      unique case (s.mode)
         cst_pkg::MODE_SLASH: begin
            r.kind    = cst_pkg::KIND_OPER;
            r.length  = cst_pkg::LengthBits'(1);
            r.op_code = cst_pkg::OP_SLASH;
         end
         cst_pkg::MODE_OPER: begin
            r.kind    = cst_pkg::KIND_OPER;
            r.op_code = s.pend_op;
         end
         cst_pkg::MODE_IDENT: r.kind = cst_pkg::KIND_IDENT;
         cst_pkg::MODE_ZERO: begin
            r.kind   = cst_pkg::KIND_INT;
            r.length = cst_pkg::LengthBits'(1);
         end
         cst_pkg::MODE_NUMBER: begin
            if (s.float_seen) begin
               r.kind = cst_pkg::KIND_FLOAT;
            end else begin
               r.kind  = cst_pkg::KIND_INT;
               r.value = s.acc;
               r.error = (s.count == '0) || s.ovf;
            end
         end
         cst_pkg::MODE_CHAR: begin
            r.kind  = cst_pkg::KIND_INT;
            r.value = {56'd0, s.first_char};
            r.error = s.count != cst_pkg::LengthBits'(1);
         end
         cst_pkg::MODE_STRING: r.kind = cst_pkg::KIND_STRING;
         default: r = '0;
      endcase
      return r;
   endfunction

   cst_pkg::lex_state_type eff;
   cst_pkg::lex_state_type idle_base;
   cst_pkg::result_type    flushed;
   cst_pkg::result_type    other_res;
   cst_pkg::result_type    end_res;
   logic                   do_flush;
   logic                   do_idle;
   logic                   is_other;
   logic [5:0]             ext_op;
   logic [4:0]             dig;
   logic [4:0]             radix;
   logic [67:0]            prod;
   logic [67:0]            sum;

   // Fold the look-ahead modes into the mode that handles this byte.
   always_comb begin
      eff = state;
      if (state.mode == cst_pkg::MODE_SLASH && in_byte != "/" && in_byte != "*") begin
         eff.mode    = cst_pkg::MODE_OPER;
         eff.pend_op = cst_pkg::OP_SLASH;
         eff.count   = cst_pkg::LengthBits'(1);
      end else if (state.mode == cst_pkg::MODE_ZERO && in_byte != "b" && in_byte != "B" &&
                   in_byte != "x" && in_byte != "X" && in_byte != ".") begin
         eff.mode       = cst_pkg::MODE_NUMBER;
         eff.base       = cst_pkg::BASE_OCT;
         eff.count      = cst_pkg::LengthBits'(1);
         eff.acc        = '0;
         eff.ovf        = 1'b0;
         eff.float_seen = 1'b0;
      end else if (state.mode > cst_pkg::MODE_STRING) begin
         eff.mode = cst_pkg::MODE_IDLE;
      end
   end

   // Digit accumulation: value times radix plus digit, with a carry-out check.
   always_comb begin
      dig = digit_value(in_byte);
      unique case (eff.base)
         cst_pkg::BASE_BIN: begin
            radix = 5'd2;
            prod  = {4'd0, eff.acc} << 1;
         end
         cst_pkg::BASE_OCT: begin
            radix = 5'd8;
            prod  = {4'd0, eff.acc} << 3;
         end
         cst_pkg::BASE_HEX: begin
            radix = 5'd16;
            prod  = {4'd0, eff.acc} << 4;
         end
         default: begin
            radix = 5'd10;
            prod  = ({4'd0, eff.acc} << 3) + ({4'd0, eff.acc} << 1);
         end
      endcase
      sum    = prod + {63'd0, dig};
      ext_op = cst_pkg::op_extend(eff.pend_op, in_byte);
   end

   // Continue the pending token, or end it and start over from idle.
   always_comb begin
      next_state = eff;
      do_flush   = 1'b0;
      do_idle    = 1'b0;
      unique case (eff.mode)
         cst_pkg::MODE_SLASH: begin
            next_state.mode = (in_byte == "/") ? cst_pkg::MODE_LINE : cst_pkg::MODE_BLOCK;
         end
         cst_pkg::MODE_LINE: begin
            if (in_byte == 8'h0A) next_state.mode = cst_pkg::MODE_IDLE;
         end
         cst_pkg::MODE_BLOCK: begin
            if (in_byte == "*") next_state.mode = cst_pkg::MODE_BSTAR;
         end
         cst_pkg::MODE_BSTAR: begin
            if (in_byte == "/") next_state.mode = cst_pkg::MODE_IDLE;
            else if (in_byte != "*") next_state.mode = cst_pkg::MODE_BLOCK;
         end
         cst_pkg::MODE_OPER: begin
            if (ext_op != cst_pkg::OP_NONE) begin
               next_state.pend_op = ext_op;
               next_state.count   = count_up(eff.count);
            end else begin
               do_flush = 1'b1;
            end
         end
         cst_pkg::MODE_IDENT: begin
            if (is_alpha(in_byte) || is_digit(in_byte)) begin
               next_state.count = count_up(eff.count);
            end else begin
               do_flush = 1'b1;
            end
         end
         cst_pkg::MODE_ZERO: begin
            next_state.mode       = cst_pkg::MODE_NUMBER;
            next_state.acc        = '0;
            next_state.ovf        = 1'b0;
            if (in_byte == ".") begin
               next_state.base       = cst_pkg::BASE_DEC;
               next_state.count      = cst_pkg::LengthBits'(2);
               next_state.float_seen = 1'b1;
            end else begin
               next_state.base  = (in_byte == "b" || in_byte == "B") ?
                                  cst_pkg::BASE_BIN : cst_pkg::BASE_HEX;
               next_state.start = pos + 1'b1;
               next_state.count = '0;
               next_state.float_seen = 1'b0;
            end
         end
         cst_pkg::MODE_NUMBER: begin
            if (dig < radix) begin
               next_state.count = count_up(eff.count);
               if (!eff.float_seen) begin
                  next_state.acc = sum[63:0];
                  next_state.ovf = eff.ovf | (|sum[67:64]);
               end
            end else if (eff.base == cst_pkg::BASE_DEC && !eff.float_seen &&
                         in_byte == ".") begin
               next_state.float_seen = 1'b1;
               next_state.count      = count_up(eff.count);
            end else begin
               do_flush = 1'b1;
            end
         end
         cst_pkg::MODE_CHAR: begin
            if (in_byte == "'") begin
               do_flush        = 1'b1;
               next_state.mode = cst_pkg::MODE_IDLE;
            end else begin
               if (eff.count == '0) next_state.first_char = in_byte;
               next_state.count = count_up(eff.count);
            end
         end
         cst_pkg::MODE_STRING: begin
            if (in_byte == 8'h22) begin
               do_flush        = 1'b1;
               next_state.mode = cst_pkg::MODE_IDLE;
            end else begin
               next_state.count = count_up(eff.count);
            end
         end
         default: do_idle = 1'b1;
      endcase
      if (do_flush && eff.mode != cst_pkg::MODE_CHAR && eff.mode != cst_pkg::MODE_STRING) begin
         do_idle = 1'b1;
      end

      // Idle handling: the byte starts a new token, is skipped or is an other token.
      idle_base      = eff;
      idle_base.mode = cst_pkg::MODE_IDLE;
      is_other       = 1'b0;
      if (do_idle) begin
         next_state = idle_base;
         if (in_byte == "/") begin
            next_state.start = pos;
            next_state.mode  = cst_pkg::MODE_SLASH;
         end else if (cst_pkg::op_index(in_byte) != cst_pkg::OP_CHAR_NONE) begin
            next_state.start   = pos;
            next_state.count   = cst_pkg::LengthBits'(1);
            next_state.pend_op = {2'b00, cst_pkg::op_index(in_byte)};
            next_state.mode    = cst_pkg::MODE_OPER;
         end else if (in_byte == "'") begin
            next_state.start      = pos + 1'b1;
            next_state.count      = '0;
            next_state.first_char = '0;
            next_state.mode       = cst_pkg::MODE_CHAR;
         end else if (in_byte == 8'h22) begin
            next_state.start = pos + 1'b1;
            next_state.count = '0;
            next_state.mode  = cst_pkg::MODE_STRING;
         end else if (in_byte == "0") begin
            next_state.start = pos;
            next_state.mode  = cst_pkg::MODE_ZERO;
         end else if (is_space(in_byte)) begin
            next_state.mode = cst_pkg::MODE_IDLE;
         end else if (is_alpha(in_byte)) begin
            next_state.start = pos;
            next_state.count = cst_pkg::LengthBits'(1);
            next_state.mode  = cst_pkg::MODE_IDENT;
         end else if (is_digit(in_byte)) begin
            next_state.base       = cst_pkg::BASE_DEC;
            next_state.start      = pos;
            next_state.count      = cst_pkg::LengthBits'(1);
            next_state.acc        = {60'd0, in_byte[3:0]};
            next_state.ovf        = 1'b0;
            next_state.float_seen = 1'b0;
            next_state.mode       = cst_pkg::MODE_NUMBER;
         end else begin
            is_other = 1'b1;
         end
      end

      if (end_of_input) begin
         next_state = cst_pkg::LEX_RESET;
      end
   end

   // Assemble up to two result items, marking the final one.
   always_comb begin
      flushed = flush_res(end_of_input ? state : eff);

      other_res            = '0;
      other_res.kind       = cst_pkg::KIND_OTHER;
      other_res.start      = pos;
      other_res.length     = cst_pkg::LengthBits'(1);
      other_res.other_char = in_byte;

      end_res       = '0;
      end_res.kind  = cst_pkg::KIND_END;
      end_res.start = pos;
      end_res.last  = 1'b1;

      res_a     = '0;
      res_b     = '0;
      res_count = 2'd0;
      if (end_of_input) begin
         if (has_token(state.mode)) begin
            res_a     = flushed;
            res_b     = end_res;
            res_count = 2'd2;
         end else begin
            res_a     = end_res;
            res_count = 2'd1;
         end
      end else if (do_flush && is_other) begin
         res_a          = flushed;
         res_b          = other_res;
         res_b.last     = 1'b1;
         res_count      = 2'd2;
      end else if (do_flush) begin
         res_a      = flushed;
         res_a.last = 1'b1;
         res_count  = 2'd1;
      end else if (is_other) begin
         res_a      = other_res;
         res_a.last = 1'b1;
         res_count  = 2'd1;
      end
   end

endmodule
